@@ rtl/fnv1_bucket_hash_macros.svh @@
// assertion macros for the fnv1 bucket hash checker
`ifndef FNV1_BUCKET_HASH_MACROS_SVH
`define FNV1_BUCKET_HASH_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define FB_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fnv1_bucket_hash check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define FB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fnv1_bucket_hash check failed");

`endif

@@ rtl/fb_pkg.sv @@
// shared types and constants for the fnv1 bucket hash block
package fb_pkg;

   localparam int KEY_W        = 8;
   localparam int INDEX_BITS_W = 5;
   localparam int LIMIT_W      = 8;
   localparam int COUNT_W      = 8;
   localparam int HASH_W       = 32;
   localparam int BUCKET_W     = 24;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [HASH_W-1:0]       FNV_BASIS          = 32'h811c9dc5;
   localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RESET   = 5'd17;
   localparam logic                    FOLD_CASE_RESET    = 1'b1;
   localparam logic                    STOP_AT_ZERO_RESET = 1'b1;
   localparam logic [LIMIT_W-1:0]      LENGTH_LIMIT_RESET = 8'd0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INDEX_BITS   = 2'd0,
      CSR_FOLD_CASE    = 2'd1,
      CSR_STOP_AT_ZERO = 2'd2,
      CSR_LENGTH_LIMIT = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [INDEX_BITS_W-1:0] index_bits;
      logic                    fold_case;
      logic                    stop_at_zero;
      logic [LIMIT_W-1:0]      length_limit;
   } cfg_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [COUNT_W-1:0] count;
      logic               stopped;
   } key_state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_byte;
      logic             key_last;
   } key_item_type;

endpackage

@@ rtl/fnv1_bucket_hash.sv @@
// top level of the streaming fnv-1a hash with bucket index fold
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_key_byte, req_key_last
//   rsp_      out        rsp_valid / rsp_ready  rsp_bucket_index, rsp_full_hash
//   csr_      in         csr_write_enable       csr_index, csr_write_data
//
// one byte item per cycle while no final byte waits for the result slot; the
// running hash loop (xor plus the shift-add prime multiply) is combinational
// after the input register; a final byte then enters the result register.
// reset is synchronous: configuration returns to defaults, the hash to the
// offset basis, and both stages empty.
// a waiting result only blocks a final byte; other bytes keep flowing.
module fnv1_bucket_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fb_pkg::KEY_W-1:0]          req_key_byte,
   input  logic                              req_key_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fb_pkg::BUCKET_W-1:0]       rsp_bucket_index,
   output logic [fb_pkg::HASH_W-1:0]         rsp_full_hash,
   input  logic                              csr_write_enable,
   input  logic [fb_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [fb_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import fb_pkg::*;

   // configuration registers
   cfg_type       cfg_ff;
   cfg_type       cfg_in;

   // running key state
   key_state_type state_ff;
   key_state_type state_in;
   key_state_type state_mixed;

   // input stage
   key_item_type  req_item;
   key_item_type  s1_item;
   logic          s1_valid;
   logic          consume;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [BUCKET_W-1:0] bucket_next;
   logic [HASH_W-1:0]   hash_ff;
   logic                load_rsp;

   assign req_item.key_byte = req_key_byte;
   assign req_item.key_last = req_key_last;

   fb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .consume    (consume),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   fb_mix u_mix (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .item         (s1_item),
      .nxt          (state_mixed),
      .bucket_index (bucket_next)
   );

   // a final byte needs a free result slot, any other byte moves on at once
   assign consume  = s1_valid && (!s1_item.key_last || !rsp_valid_ff || rsp_ready);
   assign load_rsp = consume && s1_item.key_last;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_addr_type'(csr_index))
            CSR_INDEX_BITS:   cfg_in.index_bits   = csr_write_data[INDEX_BITS_W-1:0];
            CSR_FOLD_CASE:    cfg_in.fold_case    = csr_write_data[0];
            CSR_STOP_AT_ZERO: cfg_in.stop_at_zero = csr_write_data[0];
            CSR_LENGTH_LIMIT: cfg_in.length_limit = csr_write_data[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.index_bits   <= INDEX_BITS_RESET;
         cfg_ff.fold_case    <= FOLD_CASE_RESET;
         cfg_ff.stop_at_zero <= STOP_AT_ZERO_RESET;
         cfg_ff.length_limit <= LENGTH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // key state: advance on each consumed byte, back to basis after the last
   always_comb begin
      state_in = state_ff;
      if (consume) begin
         if (s1_item.key_last) begin
            state_in.hash    = FNV_BASIS;
            state_in.count   = '0;
            state_in.stopped = 1'b0;
         end else begin
            state_in = state_mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hash    <= FNV_BASIS;
         state_ff.count   <= '0;
         state_ff.stopped <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register, refilled in the same cycle it is drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         bucket_ff <= bucket_next;
         hash_ff   <= state_mixed.hash;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = bucket_ff;
   assign rsp_full_hash    = hash_ff;

endmodule

@@ rtl/fb_in_reg.sv @@
// input register stage holding one key byte item
module fb_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fb_pkg::key_item_type req_item,
   input  logic                consume,
   output logic                item_valid,
   output fb_pkg::key_item_type item
);
   import fb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   key_item_type item_ff;

   // room when empty or when the held item leaves this cycle
   assign req_ready = !valid_ff || consume;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/fb_mix.sv @@
// per-byte hash update and bucket fold, combinational
module fb_mix (
   input  fb_pkg::cfg_type                  cfg,
   input  fb_pkg::key_state_type            cur,
   input  fb_pkg::key_item_type             item,
   output fb_pkg::key_state_type            nxt,
   output logic [fb_pkg::BUCKET_W-1:0]      bucket_index
);
   import fb_pkg::*;

   logic [KEY_W-1:0]        c;
   logic [KEY_W-1:0]        c_up;
   logic                    zero_stop;
   logic                    at_limit;
   logic                    take;
   logic [HASH_W-1:0]       m;
   logic [HASH_W-1:0]       prod;
   logic [INDEX_BITS_W-1:0] w;
   logic [5:0]              s;
   logic [HASH_W-1:0]       mask;
   logic [HASH_W-1:0]       folded;

   always_comb begin
      c         = item.key_byte;
      zero_stop = !cur.stopped && cfg.stop_at_zero && (c == '0);
      at_limit  = (cfg.length_limit != '0) && (cur.count >= cfg.length_limit);
      take      = !cur.stopped && !zero_stop && !at_limit;

      // irc casemapping: a-z and {|}~ down by 0x20
      if (cfg.fold_case && (c >= 8'h61) && (c <= 8'h7e)) begin
         c_up = c - 8'h20;
      end else begin
         c_up = c;
      end

      // multiply by the fnv prime 0x01000193 as shift-adds
      m    = cur.hash ^ {{(HASH_W-KEY_W){1'b0}}, c_up};
      prod = m + (m << 1) + (m << 4) + (m << 7) + (m << 8) + (m << 24);

      nxt         = cur;
      nxt.stopped = cur.stopped || zero_stop;
      if (take) begin
         nxt.hash = prod;
         if (cur.count != {COUNT_W{1'b1}}) begin
            nxt.count = cur.count + 1'b1;
         end
      end

      // width clamped to 1..24, mask keeps the xor form
      if (cfg.index_bits == '0) begin
         w = 5'd1;
      end else if (cfg.index_bits > 5'd24) begin
         w = 5'd24;
      end else begin
         w = cfg.index_bits;
      end
      s      = 6'd32 - {1'b0, w};
      mask   = ({26'b0, s} ^ 32'd2) - 32'd1;
      folded = (nxt.hash >> s) ^ (nxt.hash & mask);
      bucket_index = folded[BUCKET_W-1:0];
   end

endmodule

@@ rtl/fnv1_bucket_hash_chk.sv @@
// port-level checker for the fnv1 bucket hash block, bound to the top level
`include "fnv1_bucket_hash_macros.svh"

module fnv1_bucket_hash_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_key_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fb_pkg::BUCKET_W-1:0]       rsp_bucket_index,
   input logic [fb_pkg::HASH_W-1:0]         rsp_full_hash
);

   // no result right after reset
   `FB_ASSERT_IMPL(a_rsp_clear_after_reset, $past(reset), !rsp_valid)

   // with no pending result the input side never stalls
   `FB_ASSERT_IMPL(a_ready_when_drained, !rsp_valid, req_ready)

   // a fresh result comes from a final byte that passed the input register and then the result register
   `FB_ASSERT_IMPL(a_rsp_from_last, rsp_valid && !$past(rsp_valid), $past(req_valid && req_ready && req_key_last, 2))

   // a stalled result holds
   `FB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bucket_index) && $stable(rsp_full_hash))

endmodule

bind fnv1_bucket_hash fnv1_bucket_hash_chk u_chk (.*);
